/* rtl/cartridge_bank_mapper_unit_macros.svh */
// Assertion macros for the bank mapper checker.
`ifndef CARTRIDGE_BANK_MAPPER_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CBM_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbm assertion failed: name");

// Next-cycle implication, disabled in reset.
`define CBM_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbm assertion failed: name");

`endif

/* rtl/cbm_pkg.sv */
`default_nettype none
package cbm_pkg;

  // Bank count limits
  localparam int MAX_ROM_BANKS = 512;
  localparam int MAX_RAM_BANKS = 16;

  // Field widths
  localparam int ROM_CNT_W  = 10;
  localparam int RAM_CNT_W  = 5;
  localparam int MASK_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int MADDR_W    = 23;

  // Remainder unit: dividend is the 9-bit ROM bank, divisor up to 10 bits
  localparam int DVD_W     = 9;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_ADDR_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE_CART    = 3'd4;

  // Result target codes
  localparam logic [1:0] TGT_OPEN = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_RAM  = 2'd2;
  localparam logic [1:0] TGT_REG  = 2'd3;

  localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;

  // Access class decided when the beat is taken
  typedef enum logic [2:0] {
    K_OPEN,
    K_REG,
    K_ROM0,
    K_ROMX,
    K_RAM_RD,
    K_RAM_WR
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic load_out;
  } cmd_t;

  function automatic logic [ROM_CNT_W-1:0] clamp_rom(input logic [ROM_CNT_W-1:0] n);
    logic [ROM_CNT_W-1:0] r;
    if (n == '0) begin
      r = ROM_CNT_W'(1);
    end else if (n > ROM_CNT_W'(MAX_ROM_BANKS)) begin
      r = ROM_CNT_W'(MAX_ROM_BANKS);
    end else begin
      r = n;
    end
    return r;
  endfunction

  function automatic logic [RAM_CNT_W-1:0] clamp_ram(input logic [RAM_CNT_W-1:0] n);
    logic [RAM_CNT_W-1:0] r;
    if (n == '0) begin
      r = RAM_CNT_W'(1);
    end else if (n > RAM_CNT_W'(MAX_RAM_BANKS)) begin
      r = RAM_CNT_W'(MAX_RAM_BANKS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/cartridge_bank_mapper_unit.sv */
// MBC5-style cartridge bank mapper. Each input beat is one CPU bus access
// (req_type 0 read / 1 write, 16-bit bus_addr, bus_wdata); each yields exactly
// one output beat giving the target (open bus, ROM, cart RAM, register) and the
// physical byte address into external ROM or RAM. Writes to 0x0000-0x5FFF load
// the bank registers; cart RAM writes raise the sticky ram_dirty flag. The
// block works on one access at a time: an input beat is taken only when idle,
// and its output beat can leave once the 9 steps of the shared bit-serial
// remainder unit that reduces the bank number modulo the bank count have run,
// the result register loading with the last step, and then the output
// handshake follows. The next input beat is taken the cycle after the output
// beat leaves. Configuration (cfg_we/
// cfg_index/cfg_wdata) must be written only while no access is in flight.
`default_nettype none
module cartridge_bank_mapper_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // access channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           req_type,
  input  wire logic [cbm_pkg::ADDR_W-1:0]     bus_addr,
  input  wire logic [cbm_pkg::DATA_W-1:0]     bus_wdata,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          target,
  output logic [cbm_pkg::MADDR_W-1:0]         mem_addr,
  output logic                                mem_write,
  output logic [cbm_pkg::DATA_W-1:0]          mem_wdata,
  output logic                                ram_dirty
);
  import cbm_pkg::*;

  cmd_t cmd;

  // sequencing: idle -> remainder steps -> hold result
  cbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // config/bank registers, address decode, remainder unit, result register
  cbm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req_type  (req_type),
    .bus_addr  (bus_addr),
    .bus_wdata (bus_wdata),
    .target    (target),
    .mem_addr  (mem_addr),
    .mem_write (mem_write),
    .mem_wdata (mem_wdata),
    .ram_dirty (ram_dirty)
  );

endmodule
`default_nettype wire

/* rtl/cbm_ctrl.sv */
`default_nettype none
module cbm_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output cbm_pkg::cmd_t    cmd
);
  import cbm_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_step;

  assign last_step = (cnt == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        cnt_next = cnt + CNT_W'(1);
        if (last_step) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load_item = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.load_out = last_step;
      end
      S_OUT: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/cbm_datapath.sv */
`default_nettype none
module cbm_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cbm_pkg::cmd_t                  cmd,
  input  wire logic                           cfg_we,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           req_type,
  input  wire logic [cbm_pkg::ADDR_W-1:0]     bus_addr,
  input  wire logic [cbm_pkg::DATA_W-1:0]     bus_wdata,
  output logic [1:0]                          target,
  output logic [cbm_pkg::MADDR_W-1:0]         mem_addr,
  output logic                                mem_write,
  output logic [cbm_pkg::DATA_W-1:0]          mem_wdata,
  output logic                                ram_dirty
);
  import cbm_pkg::*;

  // config
  logic [ROM_CNT_W-1:0] rom_bank_count;
  logic [RAM_CNT_W-1:0] ram_bank_count;
  logic [MASK_W-1:0]    ram_addr_mask;
  logic                 ram_present;
  logic                 rumble_cart;

  // bank state
  logic [7:0] rom_bank_low;
  logic       rom_bank_high;
  logic [3:0] ram_bank;
  logic       ram_enable;
  logic       dirty_flag;

  // held item
  kind_t             kind, kind_next;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  // remainder unit
  logic [DVD_W-1:0]     dvd;
  logic [ROM_CNT_W-1:0] divisor;
  logic [ROM_CNT_W-1:0] rem;
  logic [ROM_CNT_W:0]   trial;
  logic [ROM_CNT_W-1:0] rem_next;

  logic ram_ok, in_ram_win, is_reg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= ROM_CNT_W'(2);
      ram_bank_count <= RAM_CNT_W'(1);
      ram_addr_mask  <= '0;
      ram_present    <= 1'b0;
      rumble_cart    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_wdata[ROM_CNT_W-1:0];
        CFG_RAM_BANK_COUNT: ram_bank_count <= cfg_wdata[RAM_CNT_W-1:0];
        CFG_RAM_ADDR_MASK:  ram_addr_mask  <= cfg_wdata[MASK_W-1:0];
        CFG_RAM_PRESENT:    ram_present    <= cfg_wdata[0];
        CFG_RUMBLE_CART:    rumble_cart    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ram_ok     = ram_present & ram_enable;
  assign in_ram_win = (bus_addr[15:13] == 3'b101);
  assign is_reg_wr  = req_type && (bus_addr < 16'h6000);

  always_comb begin
    kind_next = K_OPEN;
    if (req_type) begin
      if (is_reg_wr)                 kind_next = K_REG;
      else if (in_ram_win && ram_ok) kind_next = K_RAM_WR;
    end else begin
      if (bus_addr[15:14] == 2'b00)      kind_next = K_ROM0;
      else if (bus_addr[15:14] == 2'b01) kind_next = K_ROMX;
      else if (in_ram_win && ram_ok)     kind_next = K_RAM_RD;
    end
  end

  // bank registers update when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_low  <= 8'd1;
      rom_bank_high <= 1'b0;
      ram_bank      <= '0;
      ram_enable    <= 1'b0;
      dirty_flag    <= 1'b0;
    end else if (cmd.load_item) begin
      if (is_reg_wr) begin
        unique case (bus_addr[15:12])
          4'h0, 4'h1: ram_enable    <= (bus_wdata == RAM_EN_KEY);
          4'h2:       rom_bank_low  <= bus_wdata;
          4'h3:       rom_bank_high <= bus_wdata[0];
          default:    ram_bank      <= rumble_cart ? {1'b0, bus_wdata[2:0]} : bus_wdata[3:0];
        endcase
      end
      if (kind_next == K_RAM_WR) dirty_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= K_OPEN;
    end else if (cmd.load_item) begin
      kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      addr_q  <= bus_addr;
      wdata_q <= bus_wdata;
    end
  end

  // restoring remainder, one dividend bit per step
  assign trial = {rem, dvd[DVD_W-1]};
  always_comb begin
    if (trial >= {1'b0, divisor}) rem_next = ROM_CNT_W'(trial - {1'b0, divisor});
    else                          rem_next = trial[ROM_CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rem <= '0;
      if (kind_next == K_ROMX) begin
        dvd     <= {rom_bank_high, rom_bank_low};
        divisor <= clamp_rom(rom_bank_count);
      end else begin
        dvd     <= {{(DVD_W-4){1'b0}}, ram_bank};
        divisor <= {{(ROM_CNT_W-RAM_CNT_W){1'b0}}, clamp_ram(ram_bank_count)};
      end
    end else if (cmd.div_step) begin
      rem <= rem_next;
      dvd <= {dvd[DVD_W-2:0], 1'b0};
    end
  end

  // result register, loaded with the final remainder step
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ram_dirty <= dirty_flag;
      mem_write <= 1'b0;
      mem_wdata <= '0;
      mem_addr  <= '0;
      unique case (kind)
        K_OPEN:  target <= TGT_OPEN;
        K_REG:   target <= TGT_REG;
        K_ROM0: begin
          target   <= TGT_ROM;
          mem_addr <= {{(MADDR_W-14){1'b0}}, addr_q[13:0]};
        end
        K_ROMX: begin
          target   <= TGT_ROM;
          mem_addr <= {rem_next[8:0], addr_q[13:0]};
        end
        K_RAM_RD: begin
          target   <= TGT_RAM;
          mem_addr <= {6'd0, rem_next[3:0], addr_q[12:0] & ram_addr_mask};
        end
        K_RAM_WR: begin
          target    <= TGT_RAM;
          mem_addr  <= {6'd0, rem_next[3:0], addr_q[12:0] & ram_addr_mask};
          mem_write <= 1'b1;
          mem_wdata <= wdata_q;
        end
        default: target <= TGT_OPEN;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/cbm_checker.sv */
`default_nettype none
`include "cartridge_bank_mapper_unit_macros.svh"
module cbm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 target,
  input wire logic [cbm_pkg::MADDR_W-1:0] mem_addr,
  input wire logic                       mem_write,
  input wire logic                       ram_dirty
);
  import cbm_pkg::*;

  // a held result beat keeps its address
  `CBM_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mem_addr))
  // one access at a time: no input beat while a result is pending
  `CBM_ASSERT_IMP(a_one_in_flight, clk, rst, in_valid && in_ready, !out_valid)
  // fixed latency from input beat to result
  `CBM_ASSERT_IMP(a_latency, clk, rst, in_valid && in_ready, ##10 out_valid)
  // a RAM write is to cart RAM and marks it dirty
  `CBM_ASSERT_IMP(a_write_dirty, clk, rst, out_valid && mem_write, ram_dirty && (target == TGT_RAM))

endmodule

bind cartridge_bank_mapper_unit cbm_checker u_cbm_checker (.*);
`default_nettype wire

/* tb/tb_cartridge_bank_mapper_unit.sv */
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_unit;
  import cbm_pkg::*;

  // Access direction on req_type
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_RUMBLE_CART + 3'd1;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int DRAIN_CYCLES    = 24;      // idle wait once all results are in
  localparam int CYCLE_LIMIT     = 500000;

  // One result beat, field by field
  typedef struct packed {
    logic [1:0]         tgt;
    logic [MADDR_W-1:0] maddr;
    logic               mwr;
    logic [DATA_W-1:0]  mwd;
    logic               dirty;
  } map_res_t;

  localparam map_res_t RES_NONE = '0;

  // Directed table: register writes, predicted accesses, accesses with a typed result
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ACC,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  rw;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     wd;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] cval;
    map_res_t              res;
  } dir_row_t;

  // Block inputs, known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  req_type  = 1'b0;
  logic [ADDR_W-1:0]     bus_addr  = '0;
  logic [DATA_W-1:0]     bus_wdata = '0;
  logic                  out_ready = 1'b0;

  // Block outputs
  logic                  in_ready;
  logic                  out_valid;
  logic [1:0]            target;
  logic [MADDR_W-1:0]    mem_addr;
  logic                  mem_write;
  logic [DATA_W-1:0]     mem_wdata;
  logic                  ram_dirty;

  // Cartridge setup as the mapper should see it (reset values)
  logic [ROM_CNT_W-1:0]  m_rom_cnt  = 10'd2;
  logic [RAM_CNT_W-1:0]  m_ram_cnt  = 5'd1;
  logic [MASK_W-1:0]     m_ram_mask = '0;
  logic                  m_ram_on   = 1'b0;
  logic                  m_rumble   = 1'b0;

  // Bank register state (reset values)
  logic [7:0]            m_bank_lo  = 8'd1;
  logic                  m_bank_hi  = 1'b0;
  logic [3:0]            m_ram_bank = 4'd0;
  logic                  m_ram_en   = 1'b0;
  logic                  m_dirty    = 1'b0;

  map_res_t              bus_results_due [$];
  dir_row_t              dir_rows [$];
  int unsigned           mismatches    = 0;
  int unsigned           cycle_count   = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           rcv_stall_pct = 0;

  cartridge_bank_mapper_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Where an access lands and what it does to the bank registers.
  function automatic map_res_t map_access(input logic rw, input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] d);
    map_res_t    r;
    logic        ram_ok;
    logic        in_ram_win;
    int unsigned rom_n;
    int unsigned ram_n;
    int unsigned rom_bank;
    int unsigned ram_off;
    r          = RES_NONE;
    ram_ok     = m_ram_on && m_ram_en;
    in_ram_win = (a >= 16'hA000) && (a < 16'hC000);
    // zero counts act as one bank, oversized counts saturate
    rom_n = 32'(m_rom_cnt);
    if (rom_n == 0) rom_n = 1;
    else if (rom_n > MAX_ROM_BANKS) rom_n = MAX_ROM_BANKS;
    ram_n = 32'(m_ram_cnt);
    if (ram_n == 0) ram_n = 1;
    else if (ram_n > MAX_RAM_BANKS) ram_n = MAX_RAM_BANKS;
    rom_bank = 32'({m_bank_hi, m_bank_lo}) % rom_n;
    ram_off  = 32'(a[12:0] & m_ram_mask) + (32'(m_ram_bank) % ram_n) * 8192;

    if (rw == OP_WRITE) begin
      if (a < 16'h6000) begin
        r.tgt = TGT_REG;
        case (a[15:12])
          4'h0, 4'h1: m_ram_en = (d == RAM_EN_KEY);
          4'h2: m_bank_lo = d;
          4'h3: m_bank_hi = d[0];
          default: m_ram_bank = m_rumble ? {1'b0, d[2:0]} : d[3:0];
        endcase
      end else if (in_ram_win && ram_ok) begin
        r.tgt   = TGT_RAM;
        r.maddr = MADDR_W'(ram_off);
        r.mwr   = 1'b1;
        r.mwd   = d;
        m_dirty = 1'b1;
      end
    end else begin
      if (a < 16'h4000) begin
        r.tgt   = TGT_ROM;
        r.maddr = MADDR_W'(a);
      end else if (a < 16'h8000) begin
        r.tgt   = TGT_ROM;
        r.maddr = MADDR_W'(rom_bank * 16384 + 32'(a[13:0]));
      end else if (in_ram_win && ram_ok) begin
        r.tgt   = TGT_RAM;
        r.maddr = MADDR_W'(ram_off);
      end
    end
    r.dirty = m_dirty;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input map_res_t got, input map_res_t want);
    $display("[%0t] %s: got tgt=%0d addr=%h wr=%b wd=%h dirty=%b",
             $realtime, what, got.tgt, got.maddr, got.mwr, got.mwd, got.dirty,
             ", want tgt=%0d addr=%h wr=%b wd=%h dirty=%b",
             want.tgt, want.maddr, want.mwr, want.mwd, want.dirty);
    mismatches++;
  endtask

  // Register write, only with nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROM_BANK_COUNT: m_rom_cnt  = val[ROM_CNT_W-1:0];
      CFG_RAM_BANK_COUNT: m_ram_cnt  = val[RAM_CNT_W-1:0];
      CFG_RAM_ADDR_MASK:  m_ram_mask = val[MASK_W-1:0];
      CFG_RAM_PRESENT:    m_ram_on   = val[0];
      CFG_RUMBLE_CART:    m_rumble   = val[0];
      default: ;
    endcase
  endtask

  // Offer one access beat; valid stays up across back-to-back beats.
  task automatic send_access(input logic rw, input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] d, input logic typed,
                             input map_res_t typed_res);
    map_res_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= rw;
    bus_addr  <= a;
    bus_wdata <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge; bank registers move now
    pred = map_access(rw, a, d);
    bus_results_due.push_back(typed ? typed_res : pred);
  endtask

  // New cartridge geometry per phase, extremes included.
  task automatic pick_cart_setup();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = CFG_DATA_W'(1);
      2: v = CFG_DATA_W'(MAX_ROM_BANKS);
      3: v = '1;
      default: v = CFG_DATA_W'($urandom_range(1, MAX_ROM_BANKS));
    endcase
    write_reg(CFG_ROM_BANK_COUNT, v);
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = CFG_DATA_W'(1);
      2: v = CFG_DATA_W'(MAX_RAM_BANKS);
      3: v = '1;
      default: v = CFG_DATA_W'($urandom_range(1, MAX_RAM_BANKS));
    endcase
    write_reg(CFG_RAM_BANK_COUNT, v);
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      default: v = CFG_DATA_W'($urandom_range(0, 8191));
    endcase
    write_reg(CFG_RAM_ADDR_MASK, v);
    // upper bits of the one-bit registers are junk and must be dropped
    v    = CFG_DATA_W'($urandom_range(0, 8191));
    v[0] = ($urandom_range(0, 99) < 85);
    write_reg(CFG_RAM_PRESENT, v);
    write_reg(CFG_RUMBLE_CART, CFG_DATA_W'($urandom_range(0, 8191)));
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)),
                CFG_DATA_W'($urandom_range(0, 8191)));
  endtask

  // Mostly well-formed traffic: bank writes, ROM reads, cart RAM; rest is noise.
  task automatic random_access();
    int unsigned       pick;
    logic              rw;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(0, 99);
    d    = DATA_W'($urandom_range(0, 255));
    if (pick < 30) begin
      rw = OP_WRITE;
      a  = ADDR_W'($urandom_range(0, 16'h5FFF));
      if (a < 16'h2000 && $urandom_range(0, 1) == 1) d = RAM_EN_KEY;
    end else if (pick < 55) begin
      rw = OP_READ;
      a  = ADDR_W'($urandom_range(0, 16'h7FFF));
    end else if (pick < 80) begin
      rw = 1'($urandom_range(0, 1));
      a  = ADDR_W'($urandom_range(16'hA000, 16'hBFFF));
    end else begin
      rw = 1'($urandom_range(0, 1));
      a  = ADDR_W'($urandom_range(0, 16'hFFFF));
    end
    send_access(rw, a, d, 1'b0, RES_NONE);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // Result beats against the oldest expectation
  always @(posedge clk) begin : result_check
    map_res_t got;
    map_res_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{target, mem_addr, mem_write, mem_wdata, ram_dirty};
      if (bus_results_due.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding", got, RES_NONE);
      end else begin
        want = bus_results_due.pop_front();
        if (got !== want) flag_mismatch("result mismatch", got, want);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_rows = '{
      // reset geometry: 2 ROM banks, no RAM, bank 1 mapped at 0x4000
      '{ROW_TYPED, OP_READ,  16'h0000, 8'h00, 3'd0, 13'd0, '{TGT_ROM, 23'h0000, 1'b0, 8'h0, 1'b0}},
      '{ROW_TYPED, OP_READ,  16'h3FFF, 8'hFF, 3'd0, 13'd0, '{TGT_ROM, 23'h3FFF, 1'b0, 8'h0, 1'b0}},
      '{ROW_TYPED, OP_READ,  16'h4000, 8'h00, 3'd0, 13'd0, '{TGT_ROM, 23'h4000, 1'b0, 8'h0, 1'b0}},
      '{ROW_TYPED, OP_READ,  16'h7FFF, 8'h00, 3'd0, 13'd0, '{TGT_ROM, 23'h7FFF, 1'b0, 8'h0, 1'b0}},
      // cart RAM absent
      '{ROW_TYPED, OP_READ,  16'hA000, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_TYPED, OP_WRITE, 16'hBFFF, 8'h55, 3'd0, 13'd0, RES_NONE},
      // unmapped space, writes above the bank registers, then the RAM enable write
      '{ROW_TYPED, OP_READ,  16'h8000, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_TYPED, OP_WRITE, 16'hFFFF, 8'hFF, 3'd0, 13'd0, RES_NONE},
      '{ROW_TYPED, OP_WRITE, 16'h6000, 8'h12, 3'd0, 13'd0, RES_NONE},
      '{ROW_TYPED, OP_WRITE, 16'h0000, 8'h0A, 3'd0, 13'd0, '{TGT_REG, 23'h0, 1'b0, 8'h0, 1'b0}},
      // enabled but still absent
      '{ROW_TYPED, OP_READ,  16'hA000, 8'h00, 3'd0, 13'd0, RES_NONE},
      // 4 RAM banks, full mask, largest ROM
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_PRESENT,    13'd1,     RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_BANK_COUNT, 13'd4,     RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_ADDR_MASK,  13'h1FFF, RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 13'd512,  RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h4000, 8'hFF, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'hA123, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'hBFFF, 8'hAB, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h2000, 8'hFF, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h3000, 8'hFF, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'h7FFF, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h2000, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'h4000, 8'h00, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h1000, 8'h0B, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'hA000, 8'h00, 3'd0, 13'd0, RES_NONE},
      // rumble cart, zero bank counts
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RUMBLE_CART,    13'd1,     RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_BANK_COUNT, 13'd0,     RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 13'd0,     RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_ADDR_MASK,  13'd0,     RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h5FFF, 8'hFF, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h1FFF, 8'h0A, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'hA001, 8'h80, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'h5ABC, 8'h00, 3'd0, 13'd0, RES_NONE},
      // oversized counts saturate
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RAM_BANK_COUNT, 13'h1F,   RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 13'h1FFF, RES_NONE},
      '{ROW_CFG,   OP_READ,  16'h0000, 8'h00, CFG_RUMBLE_CART,    13'd0,    RES_NONE},
      '{ROW_ACC,   OP_WRITE, 16'h4FFF, 8'h0E, 3'd0, 13'd0, RES_NONE},
      '{ROW_ACC,   OP_READ,  16'hB555, 8'h00, 3'd0, 13'd0, RES_NONE}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats, no idling
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].idx, dir_rows[i].cval);
      else
        send_access(dir_rows[i].rw, dir_rows[i].addr, dir_rows[i].wd,
                    dir_rows[i].kind == ROW_TYPED, dir_rows[i].res);
    end

    // random phases, rotating through the idling patterns
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 85; rcv_stall_pct = 0;  end
        1: begin send_idle_pct = 0;  rcv_stall_pct = 85; end
        2: begin send_idle_pct = 9;  rcv_stall_pct = 9;  end
        default: begin send_idle_pct = 0; rcv_stall_pct = 0; end
      endcase
      pick_cart_setup();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_access();
    end
    in_valid <= 1'b0;

    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && bus_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/cbm_pkg.sv
rtl/cbm_ctrl.sv
rtl/cbm_datapath.sv
rtl/cartridge_bank_mapper_unit.sv
rtl/cbm_checker.sv
tb/tb_cartridge_bank_mapper_unit.sv
